// File: src/prefix_varint_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// prefix varint decoder assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef PREFIX_VARINT_DECODER_UNIT_MACROS_SVH
`define PREFIX_VARINT_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define PVDU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define PVDU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PVDU_ASSERT(label, clk, rst_n, prop, msg)
`define PVDU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: src/pvdu_pkg.sv
// ----------------------------------------------------------------------------
// pvdu_pkg
// shared types, codes and fit helpers of the prefix varint decoder
// ----------------------------------------------------------------------------
package pvdu_pkg;

    localparam int MAX_VALUE_BYTES = 8;
    localparam logic [1:0] MAX_WIDTH_CODE = 2'($clog2(MAX_VALUE_BYTES));

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_TARGET_WIDTH  = 1'b0;
    localparam logic REG_TARGET_SIGNED = 1'b1;

    localparam logic [3:0] LONG_LEN_MAX_CODE = 4'd12;
    localparam logic [4:0] LONG_LEN_BASE     = 5'd4;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_RESERVED = 2'd2
    } t_err;

    typedef struct packed {
        logic [1:0] width_code;
        logic       is_signed;
    } t_cfg;

    function automatic logic [1:0] eff_width_code(input logic [1:0] code);
        return (code > MAX_WIDTH_CODE) ? MAX_WIDTH_CODE : code;
    endfunction

    function automatic logic [63:0] width_mask(input logic [1:0] code);
        logic [63:0] m;
        case (code)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // value fits the target range
    function automatic logic fits_target(input logic [63:0] acc,
                                         input logic [1:0]  code,
                                         input logic        sgn);
        logic ok;
        case (code)
            2'd0:    ok = sgn ? ((&acc[63:7]) | ~(|acc[63:7])) : ~(|acc[63:8]);
            2'd1:    ok = sgn ? ((&acc[63:15]) | ~(|acc[63:15])) : ~(|acc[63:16]);
            2'd2:    ok = sgn ? ((&acc[63:31]) | ~(|acc[63:31])) : ~(|acc[63:32]);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

// File: src/pvdu_cfg.sv
// ----------------------------------------------------------------------------
// pvdu_cfg
// apb register block holding the target width and signedness
// ----------------------------------------------------------------------------
module pvdu_cfg
    import pvdu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [1:0] r_width_code;
    logic       r_is_signed;
    logic       w_wr;
    logic       w_index;

    assign pready  = 1'b1;
    assign w_wr    = psel & penable & pwrite & pready;
    assign w_index = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_code <= 2'd2;
            r_is_signed  <= 1'b1;
        end else if (w_wr) begin
            unique case (w_index)
                REG_TARGET_WIDTH:  r_width_code <= pwdata[1:0];
                REG_TARGET_SIGNED: r_is_signed  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_TARGET_WIDTH:  prdata = {{(APB_DATA_W-2){1'b0}}, r_width_code};
            REG_TARGET_SIGNED: prdata = {{(APB_DATA_W-1){1'b0}}, r_is_signed};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.width_code = r_width_code;
    assign o_cfg.is_signed  = r_is_signed;

endmodule

// File: src/prefix_varint_decoder_unit.sv
// ----------------------------------------------------------------------------
// prefix_varint_decoder_unit
// decodes a byte stream of prefix-length integers into fitted target values
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   request
//  s_axis    in   tdata byte_in, tuser encoded_signed       one encoded byte
//  m_axis    out  tdata value_bits, tuser error_code        one decoded value
//  apb       in   target_width_code @0, target_is_signed @4 register write
//
//  one byte per cycle unless the result stalls; decode is combinational
//  a value leaves after its last byte, or at once on an error
//  synchronous active-low reset; the next byte after reset is a lead byte
//  a stalled result holds the decode stage; the input register keeps one byte
// ----------------------------------------------------------------------------
`include "prefix_varint_decoder_unit_macros.svh"

module prefix_varint_decoder_unit
    import pvdu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,  // [7:0] byte_in
    input  logic [0:0]            i_s_axis_tuser,  // [0] encoded_signed
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [63:0]           o_m_axis_tdata,  // [63:0] value_bits
    output logic [1:0]            o_m_axis_tuser,  // [1:0] error_code
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg        w_cfg;
    logic [1:0]  w_code;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_es;

    logic [4:0]  r_rem;
    logic        r_long;
    logic        r_fit;
    logic [63:0] r_acc;
    logic [4:0]  n_rem;
    logic        n_long;
    logic        n_fit;
    logic [63:0] n_acc;

    logic        r_out_valid;
    logic [63:0] r_out_val;
    t_err        r_out_err;

    logic        w_adv;
    logic        w_emit;
    logic [63:0] w_val;
    t_err        w_err;
    logic        w_rsvd;
    logic        w_finish;
    logic        w_fit_now;
    logic        w_ok;
    logic [2:0]  w_form;
    logic [7:0]  w_dmask;
    logic        w_sbit;
    logic        w_sgn;
    logic [4:0]  w_tbytes;

    pvdu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_code   = eff_width_code(w_cfg.width_code);
    assign w_tbytes = 5'd1 << w_code;

    assign w_adv           = r_in_valid & (~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | w_adv;

    assign w_rsvd = (r_rem == 5'd0) & (&r_in_byte[7:4])
                  & (r_in_byte[3:0] > LONG_LEN_MAX_CODE);

    // lead byte classification
    always_comb begin
        w_form  = 3'd0;
        w_dmask = 8'h00;
        w_sbit  = 1'b0;
        if (!r_in_byte[7]) begin
            w_form = 3'd1; w_dmask = 8'h7F; w_sbit = r_in_byte[6];
        end else if (!r_in_byte[6]) begin
            w_form = 3'd2; w_dmask = 8'h3F; w_sbit = r_in_byte[5];
        end else if (!r_in_byte[5]) begin
            w_form = 3'd3; w_dmask = 8'h1F; w_sbit = r_in_byte[4];
        end else if (!r_in_byte[4]) begin
            w_form = 3'd4; w_dmask = 8'h0F; w_sbit = r_in_byte[3];
        end
    end

    assign w_sgn = r_in_es & w_sbit;

    always_comb begin
        n_rem     = r_rem;
        n_long    = r_long;
        n_fit     = r_fit;
        n_acc     = r_acc;
        w_emit    = 1'b0;
        w_err     = ERR_OK;
        w_val     = 64'd0;
        w_finish  = 1'b0;
        w_fit_now = r_fit;
        if (r_rem == 5'd0) begin
            if (w_form == 3'd0) begin
                if (w_rsvd) begin
                    w_emit = 1'b1;
                    w_err  = ERR_RESERVED;
                end else begin
                    n_long = 1'b1;
                    n_rem  = {1'b0, r_in_byte[3:0]} + LONG_LEN_BASE;
                    n_acc  = 64'd0;
                    n_fit  = 1'b0;
                end
            end else begin
                n_acc = {56'd0, r_in_byte & w_dmask}
                      | (w_sgn ? ~{56'd0, w_dmask} : 64'd0);
                n_fit     = w_sgn & ~w_cfg.is_signed;
                n_long    = 1'b0;
                n_rem     = {2'd0, w_form} - 5'd1;
                w_fit_now = n_fit;
                w_finish  = (w_form == 3'd1);
            end
        end else if (r_long) begin
            if (r_rem > w_tbytes) begin
                if (r_in_byte != 8'd0) begin
                    w_emit = 1'b1;
                    w_err  = ERR_OVERFLOW;
                end else begin
                    n_rem = r_rem - 5'd1;
                end
            end else begin
                n_acc = {r_acc[55:0], r_in_byte};
                n_rem = r_rem - 5'd1;
                if (r_rem == 5'd1) begin
                    w_emit = 1'b1;
                    w_val  = n_acc & width_mask(w_code);
                end
            end
        end else begin
            n_acc    = {r_acc[55:0], r_in_byte};
            n_rem    = r_rem - 5'd1;
            w_finish = (r_rem == 5'd1);
        end

        w_ok = ~w_fit_now & fits_target(n_acc, w_code, w_cfg.is_signed);
        if (w_finish) begin
            w_emit = 1'b1;
            w_err  = w_ok ? ERR_OK : ERR_OVERFLOW;
            w_val  = w_ok ? (n_acc & width_mask(w_code)) : 64'd0;
        end
        if (w_emit) begin
            n_rem = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_es   <= i_s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= 5'd0;
            r_long <= 1'b0;
            r_fit  <= 1'b0;
        end else if (w_adv) begin
            r_rem  <= n_rem;
            r_long <= n_long;
            r_fit  <= n_fit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_val <= w_val;
            r_out_err <= w_err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_val;
    assign o_m_axis_tuser  = r_out_err;

    `PVDU_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_m_axis_tvalid,
        "result valid right after reset")
    `PVDU_ASSERT(a_in_loaded, i_clk, i_rst_n,
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_in_valid,
        "accepted byte not held in input register")
    `PVDU_ASSERT(a_emit_shows, i_clk, i_rst_n,
        (w_adv && w_emit) |=> (o_m_axis_tvalid && r_rem == 5'd0),
        "emitted result not presented or item not closed")
    `PVDU_ASSERT(a_reserved_err, i_clk, i_rst_n,
        (w_adv && w_rsvd) |=> (o_m_axis_tuser == ERR_RESERVED && o_m_axis_tdata == 64'd0),
        "reserved length lead did not give a reserved error")

endmodule
